FILE: hw/rtl/easter_date_and_season_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Easter date block
// Concurrent check helpers, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef EASTER_DATE_AND_SEASON_DEFINES_SVH
`define EASTER_DATE_AND_SEASON_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EDS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EDS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/eds_pkg.sv
// ----------------------------------------------------------------------------
// eds_pkg
// Shared widths, month codes and the pipeline flow-control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eds_pkg;

    localparam int NUM_STAGES = 8;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int EMONTH_W = 3;
    localparam int EDAY_W   = 5;
    localparam int OFFSET_W = 10;
    localparam int CENT_W   = 8;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam logic [EMONTH_W-1:0] MONTH_MARCH = 3'd3;
    localparam logic [EMONTH_W-1:0] MONTH_APRIL = 3'd4;

    // Per-stage load enables and valid bits of the pipeline.
    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
        logic [NUM_STAGES-1:0] vld;
    } flow_t;

endpackage

FILE: hw/rtl/eds_flow.sv
// ----------------------------------------------------------------------------
// eds_flow
// Valid bits and per-stage load enables; a stage loads whenever it is empty
// or the stage after it moves, so bubbles collapse under a stalled output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eds_flow
    import eds_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    output flow_t flow
);

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] rdy;

    always_comb
    begin
        rdy[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        v_next[0] = rdy[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NUM_STAGES-1];
    assign flow.ld   = rdy;
    assign flow.vld  = v_reg;

endmodule

FILE: hw/rtl/eds_computus.sv
// ----------------------------------------------------------------------------
// eds_computus
// Seven-stage Gregorian computus: century, golden number, epact with its
// correction, weekday offset, then Easter month and day.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eds_computus
    import eds_pkg::*;
(
    input  logic                clk,
    input  flow_t               flow,
    input  logic [YEAR_W-1:0]   year,
    output logic [CENT_W-1:0]   cent,
    output logic [EMONTH_W-1:0] easter_month,
    output logic [EDAY_W-1:0]   easter_day
);

    // Constant divisions by reciprocal multiplication, exact over the ranges used.
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int          DIV100_SH  = 19;
    localparam logic [14:0] DIV19_MUL  = 15'd27595;
    localparam int          DIV19_SH   = 19;
    localparam logic [5:0]  DIV25_MUL  = 6'd41;
    localparam int          DIV25_SH   = 10;
    localparam logic [7:0]  DIV3_MUL   = 8'd171;
    localparam int          DIV3_SH    = 9;
    localparam logic [9:0]  DIV30_MUL  = 10'd547;
    localparam int          DIV30_SH   = 14;

    // Remainder by 7 through octal digit sums, since 8 leaves 1 modulo 7.
    function automatic logic [2:0] mod7(input logic [14:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : 3'(s2);
    endfunction

    // Stage 0
    logic [YEAR_W-1:0] y0_reg;
    logic [26:0]       pc0_reg;
    logic [28:0]       pn0_reg;

    // Stage 1
    logic [CENT_W-1:0] c1_reg;
    logic [4:0]        n1_reg;
    logic [2:0]        k1_reg;
    logic [14:0]       sy1_reg;
    logic [CENT_W-1:0] c1_next;
    logic [9:0]        nq;
    logic [4:0]        n1_next;
    logic [7:0]        kx;
    logic [12:0]       kp;
    logic [14:0]       sy1_next;

    // Stage 2
    logic [CENT_W-1:0] c2_reg;
    logic [8:0]        n19_2_reg;
    logic              nhi2_reg;
    logic [5:0]        q3_2_reg;
    logic [14:0]       sy2_reg;
    logic [7:0]        dd;
    logic [14:0]       dp;

    // Stage 3
    logic [8:0]        t3_reg;
    logic [14:0]       sp3_reg;
    logic              nhi3_reg;
    logic [8:0]        t3_next;
    logic [14:0]       sp3_next;

    // Stage 4
    logic [8:0]        t4_reg;
    logic [3:0]        tq4_reg;
    logic [14:0]       sp4_reg;
    logic              nhi4_reg;
    logic [17:0]       tp;

    // Stage 5
    logic [4:0]        i5_reg;
    logic [14:0]       s5_reg;
    logic [4:0]        i0;
    logic [4:0]        i5_next;

    // Stage 6
    logic [EMONTH_W-1:0] em6_reg;
    logic [EDAY_W-1:0]   ed6_reg;
    logic [2:0]          j;
    logic signed [5:0]   l;
    logic [EMONTH_W-1:0] em6_next;
    logic [EDAY_W-1:0]   ed6_next;

    always_ff @(posedge clk)
    begin
        if (flow.ld[0])
        begin
            y0_reg  <= year;
            pc0_reg <= 27'(year) * 27'(DIV100_MUL);
            pn0_reg <= 29'(year) * 29'(DIV19_MUL);
        end
    end

    always_comb
    begin
        c1_next  = pc0_reg[DIV100_SH+CENT_W-1:DIV100_SH];
        nq       = pn0_reg[DIV19_SH+9:DIV19_SH];
        n1_next  = 5'(y0_reg - 14'(nq) * 14'd19);
        kx       = (c1_next >= 8'd17) ? (c1_next - 8'd17) : 8'd0;
        kp       = 13'(kx) * 13'(DIV25_MUL);
        sy1_next = 15'(y0_reg) + 15'(y0_reg[YEAR_W-1:2]);
    end

    assign cent = c1_next;

    always_ff @(posedge clk)
    begin
        if (flow.ld[1])
        begin
            c1_reg  <= c1_next;
            n1_reg  <= n1_next;
            k1_reg  <= kp[DIV25_SH+2:DIV25_SH];
            sy1_reg <= sy1_next;
        end
    end

    always_comb
    begin
        dd = c1_reg - 8'(k1_reg);
        dp = 15'(dd) * 15'(DIV3_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (flow.ld[2])
        begin
            c2_reg    <= c1_reg;
            n19_2_reg <= 9'(n1_reg) * 9'd19;
            nhi2_reg  <= (n1_reg > 5'd10);
            q3_2_reg  <= dp[DIV3_SH+5:DIV3_SH];
            sy2_reg   <= sy1_reg;
        end
    end

    always_comb
    begin
        t3_next  = 9'(10'(c2_reg) - 10'(c2_reg[CENT_W-1:2]) - 10'(q3_2_reg)
                      + 10'(n19_2_reg) + 10'd15);
        sp3_next = sy2_reg + 15'd2 + 15'(c2_reg[CENT_W-1:2]) - 15'(c2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (flow.ld[3])
        begin
            t3_reg   <= t3_next;
            sp3_reg  <= sp3_next;
            nhi3_reg <= nhi2_reg;
        end
    end

    assign tp = 18'(t3_reg) * 18'(DIV30_MUL);

    always_ff @(posedge clk)
    begin
        if (flow.ld[4])
        begin
            t4_reg   <= t3_reg;
            tq4_reg  <= tp[DIV30_SH+3:DIV30_SH];
            sp4_reg  <= sp3_reg;
            nhi4_reg <= nhi3_reg;
        end
    end

    // Epact correction: 29 becomes 28, and 28 becomes 27 for a year remainder modulo 19 above ten.
    always_comb
    begin
        i0 = 5'(t4_reg - 9'(tq4_reg) * 9'd30);
        if (i0 == 5'd29)
        begin
            i5_next = 5'd28;
        end
        else if (i0 == 5'd28 && nhi4_reg)
        begin
            i5_next = 5'd27;
        end
        else
        begin
            i5_next = i0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.ld[5])
        begin
            i5_reg <= i5_next;
            s5_reg <= sp4_reg + 15'(i5_next);
        end
    end

    always_comb
    begin
        j = mod7(s5_reg);
        l = $signed({1'b0, i5_reg}) - $signed({3'b000, j});
        if (l >= 6'sd4)
        begin
            em6_next = MONTH_APRIL;
            ed6_next = 5'(l) - 5'd3;
        end
        else
        begin
            em6_next = MONTH_MARCH;
            ed6_next = 5'(l) + 5'd28;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.ld[6])
        begin
            em6_reg <= em6_next;
            ed6_reg <= ed6_next;
        end
    end

    assign easter_month = em6_reg;
    assign easter_day   = ed6_reg;

endmodule

FILE: hw/rtl/eds_offset.sv
// ----------------------------------------------------------------------------
// eds_offset
// Target day-of-year with Gregorian leap rules, carried alongside the
// computus, and the final offset and season flag in the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eds_offset
    import eds_pkg::*;
(
    input  logic                       clk,
    input  flow_t                      flow,
    input  logic [YEAR_W-1:0]          year,
    input  logic [MONTH_W-1:0]         month,
    input  logic [DAY_W-1:0]           day,
    input  logic [CENT_W-1:0]          cent,
    input  logic [EMONTH_W-1:0]        easter_month_in,
    input  logic [EDAY_W-1:0]          easter_day_in,
    output logic [EMONTH_W-1:0]        easter_month,
    output logic [EDAY_W-1:0]          easter_day,
    output logic signed [OFFSET_W-1:0] day_offset,
    output logic                       in_season
);

    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int          DIV100_SH  = 19;
    localparam int          LAST_CARRY = NUM_STAGES - 2;

    // Days before the month in a common year; month zero is the prior December,
    // months thirteen to fifteen run into the next year.
    function automatic logic signed [OFFSET_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic signed [OFFSET_W-1:0] r;
        case (m)
            4'd0:    r = -10'sd31;
            4'd1:    r = 10'sd0;
            4'd2:    r = 10'sd31;
            4'd3:    r = 10'sd59;
            4'd4:    r = 10'sd90;
            4'd5:    r = 10'sd120;
            4'd6:    r = 10'sd151;
            4'd7:    r = 10'sd181;
            4'd8:    r = 10'sd212;
            4'd9:    r = 10'sd243;
            4'd10:   r = 10'sd273;
            4'd11:   r = 10'sd304;
            4'd12:   r = 10'sd334;
            4'd13:   r = 10'sd365;
            4'd14:   r = 10'sd396;
            default: r = 10'sd424;
        endcase
        return r;
    endfunction

    logic [YEAR_W-1:0]          y0_reg;
    logic [MONTH_W-1:0]         m0_reg;
    logic [DAY_W-1:0]           d0_reg;
    logic [26:0]                pc0_reg;

    logic [CENT_W-1:0]          c_next;
    logic [YEAR_W:0]            y_next;
    logic                       leap_y;
    logic                       leap_next;
    logic [1:0]                 adj;
    logic signed [OFFSET_W-1:0] tdn_next;

    logic signed [OFFSET_W-1:0] tdn_reg  [1:LAST_CARRY];
    logic                       leap_reg [1:LAST_CARRY];

    logic [OFFSET_W-1:0]        edn;
    logic signed [OFFSET_W:0]   off_next;

    logic [EMONTH_W-1:0]        em_reg;
    logic [EDAY_W-1:0]          ed_reg;
    logic signed [OFFSET_W-1:0] off_reg;
    logic                       ins_reg;

    always_ff @(posedge clk)
    begin
        if (flow.ld[0])
        begin
            y0_reg  <= year;
            m0_reg  <= month;
            d0_reg  <= day;
            pc0_reg <= 27'(15'(year) + 15'd1) * 27'(DIV100_MUL);
        end
    end

    // Leap years of this year and the next; the next one only matters for month fifteen.
    always_comb
    begin
        c_next    = pc0_reg[DIV100_SH+CENT_W-1:DIV100_SH];
        y_next    = 15'(y0_reg) + 15'd1;
        leap_y    = (y0_reg[1:0] == 2'b00)
                    && ((y0_reg != 14'(cent) * 14'd100) || (cent[1:0] == 2'b00));
        leap_next = (y_next[1:0] == 2'b00)
                    && ((y_next != 15'(c_next) * 15'd100) || (c_next[1:0] == 2'b00));
        adj       = 2'((m0_reg >= 4'd3) && leap_y) + 2'((m0_reg == 4'd15) && leap_next);
        tdn_next  = days_before(m0_reg) + $signed({5'd0, d0_reg}) + $signed({8'd0, adj});
    end

    always_ff @(posedge clk)
    begin
        if (flow.ld[1])
        begin
            tdn_reg[1]  <= tdn_next;
            leap_reg[1] <= leap_y;
        end
        for (int k = 2; k <= LAST_CARRY; k++)
        begin
            if (flow.ld[k])
            begin
                tdn_reg[k]  <= tdn_reg[k-1];
                leap_reg[k] <= leap_reg[k-1];
            end
        end
    end

    always_comb
    begin
        edn      = ((easter_month_in == MONTH_APRIL) ? 10'd90 : 10'd59)
                   + 10'(easter_day_in) + 10'(leap_reg[LAST_CARRY]);
        off_next = $signed({tdn_reg[LAST_CARRY][OFFSET_W-1], tdn_reg[LAST_CARRY]})
                   - $signed({1'b0, edn});
    end

    always_ff @(posedge clk)
    begin
        if (flow.ld[NUM_STAGES-1])
        begin
            em_reg  <= easter_month_in;
            ed_reg  <= easter_day_in;
            off_reg <= off_next[OFFSET_W-1:0];
            ins_reg <= !off_next[OFFSET_W] && (off_next[OFFSET_W-1:0] <= 10'd48);
        end
    end

    assign easter_month = em_reg;
    assign easter_day   = ed_reg;
    assign day_offset   = off_reg;
    assign in_season    = ins_reg;

endmodule

FILE: hw/rtl/easter_date_and_season.sv
// ----------------------------------------------------------------------------
// easter_date_and_season
// Gregorian Easter Sunday of a date's year, and the date's day offset from it.
// ----------------------------------------------------------------------------
// Takes one date per cycle on the input stream and returns, once the date
// reaches the output stage, Easter's month and day for that year, the signed number
// of days from Easter to the date, and a flag set when that number is 0 to 48.
// The eight register stages each load whenever they are empty or the next
// stage moves, so the block keeps taking dates while a result waits for the
// output to be taken, and stops only when all eight stages hold items.
// Days past the end of a month roll into the following months, day zero is
// the last day of the prior month, month zero is the prior December, and
// months thirteen to fifteen fall in the next year.
`timescale 1ns / 1ps
`include "easter_date_and_season_defines.svh"

module easter_date_and_season
    import eds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // year[13:0], month[17:14], day[22:18]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // easter_month[2:0], easter_day[7:3],
                                                 // day_offset[17:8], in_season[18]
);

    flow_t                      flow;
    logic [CENT_W-1:0]          cent;
    logic [EMONTH_W-1:0]        em_cp;
    logic [EDAY_W-1:0]          ed_cp;
    logic [EMONTH_W-1:0]        easter_month;
    logic [EDAY_W-1:0]          easter_day;
    logic signed [OFFSET_W-1:0] day_offset;
    logic                       in_season;

    eds_flow u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .flow      (flow)
    );

    eds_computus u_computus (
        .clk          (clk),
        .flow         (flow),
        .year         (s_axis_tdata[13:0]),
        .cent         (cent),
        .easter_month (em_cp),
        .easter_day   (ed_cp)
    );

    eds_offset u_offset (
        .clk             (clk),
        .flow            (flow),
        .year            (s_axis_tdata[13:0]),
        .month           (s_axis_tdata[17:14]),
        .day             (s_axis_tdata[22:18]),
        .cent            (cent),
        .easter_month_in (em_cp),
        .easter_day_in   (ed_cp),
        .easter_month    (easter_month),
        .easter_day      (easter_day),
        .day_offset      (day_offset),
        .in_season       (in_season)
    );

    assign m_axis_tdata = {5'd0, in_season, day_offset, easter_day, easter_month};

    `EDS_ASSERT_NOW(a_full_only_when_blocked, s_axis_tvalid && !s_axis_tready,
        m_axis_tvalid && !m_axis_tready, "input stalled while output is not blocked")

    `EDS_ASSERT_NEXT(a_accept_fills_stage, s_axis_tvalid && s_axis_tready,
        flow.vld[0], "accepted transfer did not enter the first stage")

    `EDS_ASSERT_NOW(a_easter_window, m_axis_tvalid,
        (easter_month == MONTH_MARCH && easter_day >= 5'd22)
        || (easter_month == MONTH_APRIL && easter_day >= 5'd1 && easter_day <= 5'd25),
        "Easter date outside March 22 to April 25")

    `EDS_ASSERT_NOW(a_season_flag, m_axis_tvalid,
        in_season == (!day_offset[OFFSET_W-1] && day_offset[OFFSET_W-2:0] <= 9'd48),
        "season flag disagrees with day offset")

endmodule
